>>> hdl/two_bone_vertex_skinning_core_defines.svh
// Assertion helpers used by the checker of this block.
`ifndef TWO_BONE_VERTEX_SKINNING_CORE_DEFINES_SVH
`define TWO_BONE_VERTEX_SKINNING_CORE_DEFINES_SVH

// Property checked on every rising edge, ignored while reset is asserted.
`define SKN_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Property checked on every rising edge, reset included.
`define SKN_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

>>> hdl/skn_pkg.sv
package skn_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int WEIGHT_BITS = 8;
    localparam int WEIGHT_ONE  = 1 << WEIGHT_BITS;

    localparam int COORD_W  = 16;
    localparam int WEIGHT_W = WEIGHT_BITS + 1;
    localparam int ROW_W    = 4 * COORD_W;
    localparam int PROD_W   = 2 * COORD_W;
    // three products plus the shifted translation, with headroom
    localparam int DOT_W    = PROD_W + 2;
    localparam int WPROD_W  = DOT_W + WEIGHT_W + 1;
    localparam int SUM_W    = WPROD_W + 1;
    localparam int SHIFT    = FRAC_BITS + WEIGHT_BITS;

    localparam logic [ROW_W-1:0] IDENT_ROW0 = ROW_W'(1) << FRAC_BITS;
    localparam logic [ROW_W-1:0] IDENT_ROW1 = ROW_W'(1) << (COORD_W + FRAC_BITS);
    localparam logic [ROW_W-1:0] IDENT_ROW2 = ROW_W'(1) << (2 * COORD_W + FRAC_BITS);

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A_ROW0 = 3'd0,
        REG_A_ROW1 = 3'd1,
        REG_A_ROW2 = 3'd2,
        REG_B_ROW0 = 3'd3,
        REG_B_ROW1 = 3'd4,
        REG_B_ROW2 = 3'd5
    } t_cfg_idx;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [WEIGHT_W-1:0]       t_weight;
    typedef logic signed [DOT_W-1:0]   t_dot;

endpackage

>>> hdl/skn_vert_if.sv
interface skn_vert_if;
    logic                   valid;
    logic                   ready;
    skn_pkg::t_coord        vert_x;
    skn_pkg::t_coord        vert_y;
    skn_pkg::t_coord        vert_z;
    skn_pkg::t_weight       blend_weight;

    modport source (output valid, vert_x, vert_y, vert_z, blend_weight, input ready);
    modport sink   (input valid, vert_x, vert_y, vert_z, blend_weight, output ready);
endinterface

>>> hdl/skn_res_if.sv
interface skn_res_if;
    logic                   valid;
    logic                   ready;
    skn_pkg::t_coord        out_x;
    skn_pkg::t_coord        out_y;
    skn_pkg::t_coord        out_z;
    logic                   saturated;

    modport source (output valid, out_x, out_y, out_z, saturated, input ready);
    modport sink   (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

>>> hdl/skn_row_dot.sv
module skn_row_dot (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [skn_pkg::ROW_W-1:0]     i_row,
    input  skn_pkg::t_coord               i_vx,
    input  skn_pkg::t_coord               i_vy,
    input  skn_pkg::t_coord               i_vz,
    output skn_pkg::t_dot                 o_dot
);

    localparam int CW = skn_pkg::COORD_W;
    localparam int PW = skn_pkg::PROD_W;
    localparam int DW = skn_pkg::DOT_W;
    localparam int FB = skn_pkg::FRAC_BITS;

    skn_pkg::t_coord        w_e0, w_e1, w_e2, w_e3;
    logic signed [PW-1:0]   r_p0, r_p1, r_p2;
    skn_pkg::t_coord        r_trans;
    skn_pkg::t_dot          w_trans_ext;
    skn_pkg::t_dot          n_dot;
    skn_pkg::t_dot          r_dot;

    assign w_e0 = i_row[0*CW +: CW];
    assign w_e1 = i_row[1*CW +: CW];
    assign w_e2 = i_row[2*CW +: CW];
    assign w_e3 = i_row[3*CW +: CW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0    <= PW'(w_e0) * PW'(i_vx);
            r_p1    <= PW'(w_e1) * PW'(i_vy);
            r_p2    <= PW'(w_e2) * PW'(i_vz);
            r_trans <= w_e3;
        end
    end

    // translation is scaled by the implied w = 1.0 of the vertex
    assign w_trans_ext = {{(DW - CW - FB){r_trans[CW-1]}}, r_trans, {FB{1'b0}}};

    always_comb begin
        n_dot = DW'(r_p0) + DW'(r_p1) + DW'(r_p2) + w_trans_ext;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dot <= n_dot;
        end
    end

    assign o_dot = r_dot;

endmodule

>>> hdl/skn_blend.sv
module skn_blend (
    input  logic                i_clk,
    input  logic                i_en,
    input  skn_pkg::t_dot       i_pa,
    input  skn_pkg::t_dot       i_pb,
    input  skn_pkg::t_weight    i_wa,
    input  skn_pkg::t_weight    i_wb,
    output skn_pkg::t_coord     o_coord,
    output logic                o_sat
);

    localparam int WPW = skn_pkg::WPROD_W;
    localparam int SW  = skn_pkg::SUM_W;
    localparam int CW  = skn_pkg::COORD_W;
    localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) << (skn_pkg::SHIFT - 1);
    localparam logic signed [SW-1:0] MAX_V = SW'((1 << (CW - 1)) - 1);
    localparam logic signed [SW-1:0] MIN_V = -(SW'(1) << (CW - 1));

    logic signed [skn_pkg::WEIGHT_W:0] w_wa_s, w_wb_s;
    logic signed [WPW-1:0]             r_ta, r_tb;
    logic signed [SW-1:0]              n_sum;
    logic signed [SW-1:0]              n_shr;
    skn_pkg::t_coord                   n_coord;
    logic                              n_sat;
    skn_pkg::t_coord                   r_coord;
    logic                              r_sat;

    assign w_wa_s = {1'b0, i_wa};
    assign w_wb_s = {1'b0, i_wb};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ta <= WPW'(i_pa) * WPW'(w_wa_s);
            r_tb <= WPW'(i_pb) * WPW'(w_wb_s);
        end
    end

    // round half up, then clip to the coordinate range
    always_comb begin
        n_sum = SW'(r_ta) + SW'(r_tb) + ROUND_HALF;
        n_shr = n_sum >>> skn_pkg::SHIFT;
        if (n_shr > MAX_V) begin
            n_coord = MAX_V[CW-1:0];
            n_sat   = 1'b1;
        end else if (n_shr < MIN_V) begin
            n_coord = MIN_V[CW-1:0];
            n_sat   = 1'b1;
        end else begin
            n_coord = n_shr[CW-1:0];
            n_sat   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_coord <= n_coord;
            r_sat   <= n_sat;
        end
    end

    assign o_coord = r_coord;
    assign o_sat   = r_sat;

endmodule

>>> hdl/two_bone_vertex_skinning_core.sv
// Two-bone linear blend skinning: each request carries one rest-pose vertex and the weight of
// bone B; the block returns (1-w)*A*v + w*B*v rounded to the input fixed-point format and
// clipped to 16 bits, with a flag when any coordinate was clipped. One vertex is taken every
// cycle unless the output stalls, through four register stages: a product stage of 16x16
// multipliers, a row sum, the weight multiply and the round/clip stage. A stalled output
// freezes the whole pipeline, so ready follows the output side in the same cycle. Both bone
// matrices reset to identity and may be rewritten only while no vertex is in flight.
module two_bone_vertex_skinning_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [skn_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [skn_pkg::ROW_W-1:0]         i_cfg_data,
    skn_vert_if.sink                          i_vert,
    skn_res_if.source                         o_res
);

    localparam int NSTG = 4;

    logic [skn_pkg::ROW_W-1:0] r_mat_a [3];
    logic [skn_pkg::ROW_W-1:0] r_mat_b [3];
    logic [NSTG-1:0]           r_valid;
    logic [NSTG-1:0]           n_valid;
    logic                      w_adv;
    skn_pkg::t_weight          n_wb, n_wa;
    skn_pkg::t_weight          r_wa1, r_wb1, r_wa2, r_wb2;
    skn_pkg::t_dot             w_pa [3];
    skn_pkg::t_dot             w_pb [3];
    skn_pkg::t_coord           w_coord [3];
    logic [2:0]                w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat_a[0] <= skn_pkg::IDENT_ROW0;
            r_mat_a[1] <= skn_pkg::IDENT_ROW1;
            r_mat_a[2] <= skn_pkg::IDENT_ROW2;
            r_mat_b[0] <= skn_pkg::IDENT_ROW0;
            r_mat_b[1] <= skn_pkg::IDENT_ROW1;
            r_mat_b[2] <= skn_pkg::IDENT_ROW2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                skn_pkg::REG_A_ROW0: r_mat_a[0] <= i_cfg_data;
                skn_pkg::REG_A_ROW1: r_mat_a[1] <= i_cfg_data;
                skn_pkg::REG_A_ROW2: r_mat_a[2] <= i_cfg_data;
                skn_pkg::REG_B_ROW0: r_mat_b[0] <= i_cfg_data;
                skn_pkg::REG_B_ROW1: r_mat_b[1] <= i_cfg_data;
                skn_pkg::REG_B_ROW2: r_mat_b[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance every stage together unless the finished result is held
    assign w_adv        = !r_valid[NSTG-1] || o_res.ready;
    assign i_vert.ready = w_adv;
    assign n_valid      = {r_valid[NSTG-2:0], i_vert.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_adv) begin
            r_valid <= n_valid;
        end
    end

    // weights above one count as one
    always_comb begin
        if (i_vert.blend_weight > skn_pkg::WEIGHT_W'(skn_pkg::WEIGHT_ONE)) begin
            n_wb = skn_pkg::WEIGHT_W'(skn_pkg::WEIGHT_ONE);
        end else begin
            n_wb = i_vert.blend_weight;
        end
        n_wa = skn_pkg::WEIGHT_W'(skn_pkg::WEIGHT_ONE) - n_wb;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_wa1 <= n_wa;
            r_wb1 <= n_wb;
            r_wa2 <= r_wa1;
            r_wb2 <= r_wb1;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_row
        skn_row_dot u_dot_a (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_row (r_mat_a[i]),
            .i_vx  (i_vert.vert_x),
            .i_vy  (i_vert.vert_y),
            .i_vz  (i_vert.vert_z),
            .o_dot (w_pa[i])
        );

        skn_row_dot u_dot_b (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_row (r_mat_b[i]),
            .i_vx  (i_vert.vert_x),
            .i_vy  (i_vert.vert_y),
            .i_vz  (i_vert.vert_z),
            .o_dot (w_pb[i])
        );

        skn_blend u_blend (
            .i_clk   (i_clk),
            .i_en    (w_adv),
            .i_pa    (w_pa[i]),
            .i_pb    (w_pb[i]),
            .i_wa    (r_wa2),
            .i_wb    (r_wb2),
            .o_coord (w_coord[i]),
            .o_sat   (w_sat[i])
        );
    end

    assign o_res.valid     = r_valid[NSTG-1];
    assign o_res.out_x     = w_coord[0];
    assign o_res.out_y     = w_coord[1];
    assign o_res.out_z     = w_coord[2];
    assign o_res.saturated = |w_sat;

endmodule

>>> hdl/skn_checker.sv
`include "two_bone_vertex_skinning_core_defines.svh"

module skn_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  skn_pkg::t_coord    i_out_x,
    input  skn_pkg::t_coord    i_out_y,
    input  skn_pkg::t_coord    i_out_z,
    input  logic               i_out_sat
);

    localparam skn_pkg::t_coord CMAX = skn_pkg::t_coord'((1 << (skn_pkg::COORD_W - 1)) - 1);
    localparam skn_pkg::t_coord CMIN = ~CMAX;

    // a waiting request stays offered
    `SKN_ASSERT(a_in_hold, i_clk, i_rst_n, (i_in_valid && !i_in_ready) |=> i_in_valid)

    // a held result keeps its value
    `SKN_ASSERT(a_out_hold, i_clk, i_rst_n,
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable({i_out_x, i_out_y, i_out_z, i_out_sat})))

    // a held result stalls the input side
    `SKN_ASSERT(a_stall_in, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |-> !i_in_ready)

    // clipping leaves at least one coordinate on a bound
    `SKN_ASSERT(a_sat_bound, i_clk, i_rst_n,
        (i_out_valid && i_out_sat) |->
        (i_out_x == CMAX || i_out_x == CMIN || i_out_y == CMAX ||
         i_out_y == CMIN || i_out_z == CMAX || i_out_z == CMIN))

    // reset empties the pipeline
    `SKN_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind two_bone_vertex_skinning_core skn_checker u_skn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_vert.valid),
    .i_in_ready  (i_vert.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_x     (o_res.out_x),
    .i_out_y     (o_res.out_y),
    .i_out_z     (o_res.out_z),
    .i_out_sat   (o_res.saturated)
);
